[rtl/bounded_ordered_list_defines.svh]
// Assertion macros for the bounded ordered list.
// Needs clk_i and rst_ni in the module that uses them.
`ifndef BOUNDED_ORDERED_LIST_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_DEFINES_SVH

// Same-cycle implication.
`define BOL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bounded_ordered_list: check failed");

// Next-cycle implication.
`define BOL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bounded_ordered_list: check failed");

`endif

[rtl/bol_pkg.sv]
// Package for the bounded ordered list: sizes, operation codes and
// the request and result structs. No dependencies.
package bol_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

  typedef enum logic [3:0] {
    KIND_APPEND    = 4'd0,
    KIND_PREPEND   = 4'd1,
    KIND_INSERT_AT = 4'd2,
    KIND_DEL_VALUE = 4'd3,
    KIND_DEL_LAST  = 4'd4,
    KIND_DEL_FIRST = 4'd5,
    KIND_DEL_AT    = 4'd6,
    KIND_CLEAR     = 4'd7,
    KIND_READ      = 4'd8
  } kind_e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  position;
    logic [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic        succeeded;
    logic [4:0]  entry_count;
    logic        is_empty;
    logic [31:0] first_value;
    logic [31:0] last_value;
    logic [31:0] read_value;
  } rsp_t;

endpackage

[rtl/bounded_ordered_list.sv]
// Bounded ordered list: sequencer, entry store and result register.
// Depends on bol_pkg and bounded_ordered_list_defines.svh.
//
//   channel | dir | payload          | handshake
//   --------+-----+------------------+-------------------------------
//   in      | in  | in_req_i (req_t) | in_valid_i / in_stall_o
//   out     | out | out_rsp_o(rsp_t) | out_valid_o / out_stall_i
//   cfg     | in  | cfg_wdata_i      | cfg_we_i (capacity)
//
// Requests walk the sequencer: insert shifts entries up (ST_SHIFT) and writes
// the value (ST_PUT), delete shifts down, delete value searches first
// (ST_SEARCH); all then read first, last and addressed entries (ST_FETCH).
// Reset empties the list and sets capacity to 16; the store is not cleared.
// A finished result waits in the output register; the next request is taken
// meanwhile and its result waits in the last sequencer state.
`include "bounded_ordered_list_defines.svh"

module bounded_ordered_list (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [4:0]    cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bol_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bol_pkg::rsp_t out_rsp_o
);
  import bol_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PUT,
    ST_SEARCH,
    ST_FETCH,
    ST_DONE
  } state_e;

  state_e                 state_q, state_d;
  logic [4:0]             cap_q;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [3:0]             kind_q, kind_d;
  logic [3:0]             pos_q, pos_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic                   ok_q, ok_d;
  logic [IDX_W-1:0]       ptr_q, ptr_d;
  logic [IDX_W-1:0]       wptr_q, wptr_d;
  logic [IDX_W-1:0]       gap_q, gap_d;
  logic [IDX_W-1:0]       chk_idx_q, chk_idx_d;
  logic [CNT_W-1:0]       left_q, left_d;
  logic                   dir_up_q, dir_up_d;
  logic                   pend_q, pend_d;
  logic                   chk_q, chk_d;
  logic [1:0]             fs_q, fs_d;
  logic [VALUE_WIDTH-1:0] first_q, first_d;
  logic [VALUE_WIDTH-1:0] last_q, last_d;
  logic [VALUE_WIDTH-1:0] rdv_q, rdv_d;
  logic                   out_valid_q, out_valid_d;
  rsp_t                   out_q, out_d;

  // entry store, one write and one registered read a cycle
  logic [VALUE_WIDTH-1:0] entries_q [DEPTH];
  logic [VALUE_WIDTH-1:0] rdata_q;
  logic                   rd_en, wr_en;
  logic [IDX_W-1:0]       rd_addr, wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;

  logic [CNT_W-1:0]       room;
  logic                   can_add;

  assign room       = (32'(cap_q) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(cap_q);
  assign can_add    = cnt_q < room;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_comb begin
    logic             ins;
    logic             del;
    logic [CNT_W-1:0] gap;
    logic [CNT_W-1:0] del_at;
    logic [CMP_W-1:0] pos_w;
    logic [CMP_W-1:0] cnt_w;

    ins    = 1'b0;
    del    = 1'b0;
    gap    = '0;
    del_at = '0;
    pos_w  = CMP_W'(in_req_i.position);
    cnt_w  = CMP_W'(cnt_q);

    state_d     = state_q;
    cnt_d       = cnt_q;
    kind_d      = kind_q;
    pos_d       = pos_q;
    val_d       = val_q;
    ok_d        = ok_q;
    ptr_d       = ptr_q;
    wptr_d      = wptr_q;
    gap_d       = gap_q;
    chk_idx_d   = chk_idx_q;
    left_d      = left_q;
    dir_up_d    = dir_up_q;
    pend_d      = 1'b0;
    chk_d       = 1'b0;
    fs_d        = fs_q;
    first_d     = first_q;
    last_d      = last_q;
    rdv_d       = rdv_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    rd_en   = 1'b0;
    rd_addr = '0;
    // pending shift write lands in the cycle after its read
    wr_en   = pend_q;
    wr_addr = wptr_q;
    wr_data = rdata_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d  = in_req_i.kind;
          pos_d   = in_req_i.position;
          val_d   = VALUE_WIDTH'(in_req_i.item_value);
          ok_d    = 1'b0;
          fs_d    = '0;
          state_d = ST_FETCH;
          unique case (in_req_i.kind)
            KIND_APPEND: begin
              ins = can_add;
              gap = cnt_q;
            end
            KIND_PREPEND: begin
              ins = can_add;
              gap = '0;
            end
            KIND_INSERT_AT: begin
              ins = can_add && (pos_w <= cnt_w);
              gap = CNT_W'(in_req_i.position);
            end
            KIND_DEL_VALUE: begin
              ptr_d   = '0;
              left_d  = cnt_q;
              state_d = ST_SEARCH;
            end
            KIND_DEL_LAST: begin
              if (cnt_q != '0) begin
                cnt_d = cnt_q - CNT_W'(1);
                ok_d  = 1'b1;
              end
            end
            KIND_DEL_FIRST: begin
              del    = (cnt_q != '0);
              del_at = '0;
            end
            KIND_DEL_AT: begin
              del    = (pos_w < cnt_w);
              del_at = CNT_W'(in_req_i.position);
            end
            KIND_CLEAR: begin
              cnt_d = '0;
              ok_d  = 1'b1;
            end
            KIND_READ: begin
              ok_d = (pos_w < cnt_w);
            end
            default: begin
            end
          endcase
          if (ins) begin
            ok_d     = 1'b1;
            cnt_d    = cnt_q + CNT_W'(1);
            gap_d    = IDX_W'(gap);
            ptr_d    = IDX_W'(cnt_q - CNT_W'(1));
            left_d   = cnt_q - gap;
            dir_up_d = 1'b1;
            state_d  = ST_SHIFT;
          end
          if (del) begin
            ok_d     = 1'b1;
            cnt_d    = cnt_q - CNT_W'(1);
            ptr_d    = IDX_W'(del_at + CNT_W'(1));
            left_d   = cnt_q - CNT_W'(1) - del_at;
            dir_up_d = 1'b0;
            state_d  = ST_SHIFT;
          end
        end
      end

      ST_SHIFT: begin
        if (left_q != '0) begin
          rd_en   = 1'b1;
          rd_addr = ptr_q;
          pend_d  = 1'b1;
          wptr_d  = dir_up_q ? ptr_q + IDX_W'(1) : ptr_q - IDX_W'(1);
          ptr_d   = dir_up_q ? ptr_q - IDX_W'(1) : ptr_q + IDX_W'(1);
          left_d  = left_q - CNT_W'(1);
        end else begin
          state_d = dir_up_q ? ST_PUT : ST_FETCH;
        end
      end

      ST_PUT: begin
        wr_en   = 1'b1;
        wr_addr = gap_q;
        wr_data = val_q;
        state_d = ST_FETCH;
      end

      ST_SEARCH: begin
        if (chk_q && (rdata_q == val_q)) begin
          // hit: close the gap at the matching entry
          ok_d     = 1'b1;
          cnt_d    = cnt_q - CNT_W'(1);
          ptr_d    = chk_idx_q + IDX_W'(1);
          left_d   = cnt_q - CNT_W'(1) - CNT_W'(chk_idx_q);
          dir_up_d = 1'b0;
          state_d  = ST_SHIFT;
        end else if (left_q != '0) begin
          rd_en     = 1'b1;
          rd_addr   = ptr_q;
          chk_d     = 1'b1;
          chk_idx_d = ptr_q;
          ptr_d     = ptr_q + IDX_W'(1);
          left_d    = left_q - CNT_W'(1);
        end else begin
          state_d = ST_FETCH;
        end
      end

      ST_FETCH: begin
        fs_d = fs_q + 2'd1;
        unique case (fs_q)
          2'd0: begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end
          2'd1: begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(cnt_q - CNT_W'(1));
            first_d = rdata_q;
          end
          2'd2: begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(pos_q);
            last_d  = rdata_q;
          end
          default: begin
            rdv_d   = rdata_q;
            state_d = ST_DONE;
          end
        endcase
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          out_d.succeeded   = ok_q;
          out_d.entry_count = 5'(cnt_q);
          out_d.is_empty    = (cnt_q == '0);
          out_d.first_value = (cnt_q == '0) ? 32'd0 : 32'(first_q);
          out_d.last_value  = (cnt_q == '0) ? 32'd0 : 32'(last_q);
          out_d.read_value  = (ok_q && (kind_q == KIND_READ)) ? 32'(rdv_q) : 32'd0;
          state_d           = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= 5'd16;
      cnt_q       <= '0;
      kind_q      <= '0;
      pos_q       <= '0;
      val_q       <= '0;
      ok_q        <= 1'b0;
      ptr_q       <= '0;
      wptr_q      <= '0;
      gap_q       <= '0;
      chk_idx_q   <= '0;
      left_q      <= '0;
      dir_up_q    <= 1'b0;
      pend_q      <= 1'b0;
      chk_q       <= 1'b0;
      fs_q        <= '0;
      first_q     <= '0;
      last_q      <= '0;
      rdv_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      cnt_q       <= cnt_d;
      kind_q      <= kind_d;
      pos_q       <= pos_d;
      val_q       <= val_d;
      ok_q        <= ok_d;
      ptr_q       <= ptr_d;
      wptr_q      <= wptr_d;
      gap_q       <= gap_d;
      chk_idx_q   <= chk_idx_d;
      left_q      <= left_d;
      dir_up_q    <= dir_up_d;
      pend_q      <= pend_d;
      chk_q       <= chk_d;
      fs_q        <= fs_d;
      first_q     <= first_d;
      last_q      <= last_d;
      rdv_q       <= rdv_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entries_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= entries_q[rd_addr];
    end
  end

  `BOL_ASSERT_IMP(a_cnt_bound, 1'b1, 32'(cnt_q) <= DEPTH)
  `BOL_ASSERT_NXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o)
  `BOL_ASSERT_IMP(a_no_write_clash, state_q == ST_PUT || state_q == ST_SEARCH || state_q == ST_IDLE, !pend_q)
  `BOL_ASSERT_NXT(a_result_held, out_valid_q && out_stall_i, out_valid_q && $stable(out_q))

endmodule

[tb/tb_bounded_ordered_list.sv]
`timescale 1ns / 100ps
// Testbench for bounded_ordered_list: directed table, then random list traffic in several
// capacity phases, each result checked against the table's or an in-bench predictor's.
// Depends on bol_pkg and the bounded_ordered_list RTL.

module tb_bounded_ordered_list;
  import bol_pkg::*;

  localparam logic [3:0] KIND_FIRST_UNUSED = 4'd9;
  localparam logic [3:0] KIND_LAST_UNUSED  = 4'd15;
  localparam int         PHASES            = 10;
  localparam int         PHASE_REQUESTS    = 125;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  req_t       in_req = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  rsp_t       out_rsp;

  // predictor state
  logic [31:0] shadow_list [DEPTH];
  int unsigned shadow_count;
  logic [4:0]  shadow_capacity;

  rsp_t        expected_rsps [$];
  rsp_t        oldest_rsp;
  dir_row_t    stimulus_table [$];
  int          mismatch_count = 0;
  bit          no_idle = 1'b0;
  int          stall_left = 0;

  bounded_ordered_list dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  always #5 clk = ~clk;

  function automatic void open_slot(int unsigned at, logic [31:0] v);
    for (int unsigned i = shadow_count; i > at; i--) shadow_list[i] = shadow_list[i - 1];
    shadow_list[at] = v;
    shadow_count++;
  endfunction

  function automatic void close_slot(int unsigned at);
    for (int unsigned i = at; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i + 1];
    shadow_count--;
  endfunction

  function automatic rsp_t apply_list_op(req_t r);
    rsp_t        res;
    int unsigned room;
    int unsigned pos;
    logic        ok;
    logic [31:0] rd;
    room = (shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
    pos  = r.position;
    ok   = 1'b0;
    rd   = '0;
    case (r.kind)
      KIND_APPEND: begin
        if (shadow_count < room) begin
          open_slot(shadow_count, r.item_value);
          ok = 1'b1;
        end
      end
      KIND_PREPEND: begin
        if (shadow_count < room) begin
          open_slot(0, r.item_value);
          ok = 1'b1;
        end
      end
      KIND_INSERT_AT: begin
        if (shadow_count < room && pos <= shadow_count) begin
          open_slot(pos, r.item_value);
          ok = 1'b1;
        end
      end
      KIND_DEL_VALUE: begin
        for (int unsigned i = 0; i < shadow_count; i++) begin
          if (shadow_list[i] == r.item_value) begin
            close_slot(i);
            ok = 1'b1;
            break;
          end
        end
      end
      KIND_DEL_LAST: begin
        if (shadow_count > 0) begin
          shadow_count--;
          ok = 1'b1;
        end
      end
      KIND_DEL_FIRST: begin
        if (shadow_count > 0) begin
          close_slot(0);
          ok = 1'b1;
        end
      end
      KIND_DEL_AT: begin
        if (pos < shadow_count) begin
          close_slot(pos);
          ok = 1'b1;
        end
      end
      KIND_CLEAR: begin
        shadow_count = 0;
        ok = 1'b1;
      end
      KIND_READ: begin
        if (pos < shadow_count) begin
          rd = shadow_list[pos];
          ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.succeeded   = ok;
    res.entry_count = shadow_count[4:0];
    res.is_empty    = (shadow_count == 0);
    res.first_value = (shadow_count > 0) ? shadow_list[0] : '0;
    res.last_value  = (shadow_count > 0) ? shadow_list[shadow_count - 1] : '0;
    res.read_value  = rd;
    return res;
  endfunction

  function automatic rsp_t mk_rsp(logic ok, logic [4:0] cnt, logic [31:0] first,
                                  logic [31:0] last);
    rsp_t res;
    res.succeeded   = ok;
    res.entry_count = cnt;
    res.is_empty    = (cnt == 0);
    res.first_value = first;
    res.last_value  = last;
    res.read_value  = '0;
    return res;
  endfunction

  function automatic void add_row(logic [3:0] kind, logic [3:0] pos, logic [31:0] value,
                                  bit typed = 1'b0, rsp_t want = '0);
    dir_row_t row;
    row.req.kind       = kind;
    row.req.position   = pos;
    row.req.item_value = value;
    row.typed          = typed;
    row.want           = want;
    stimulus_table.push_back(row);
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return 32'($urandom_range(0, 7));   // small pool makes duplicates
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t random_request(int unsigned grow_pct);
    req_t        r;
    int unsigned sel;
    int unsigned last_idx;
    int unsigned top_pos;
    r.position   = 4'($urandom_range(0, 15));
    r.item_value = random_value();
    r.kind       = KIND_READ;
    last_idx     = (shadow_count > 0) ? shadow_count - 1 : 0;
    top_pos      = (shadow_count > 15) ? 15 : shadow_count;
    sel          = $urandom_range(0, 99);
    if (sel < 3) begin
      r.kind = 4'($urandom_range(KIND_FIRST_UNUSED, KIND_LAST_UNUSED));
    end else if (sel < 3 + grow_pct * 97 / 100) begin
      case ($urandom_range(0, 2))
        0: r.kind = KIND_APPEND;
        1: r.kind = KIND_PREPEND;
        default: begin
          r.kind = KIND_INSERT_AT;
          if ($urandom_range(0, 7) != 0) r.position = 4'($urandom_range(0, top_pos));
        end
      endcase
    end else begin
      case ($urandom_range(0, 9))
        0, 1: begin
          r.kind = KIND_DEL_VALUE;
          if (shadow_count > 0 && $urandom_range(0, 3) != 0)
            r.item_value = shadow_list[$urandom_range(0, last_idx)];
        end
        2: r.kind = KIND_DEL_LAST;
        3: r.kind = KIND_DEL_FIRST;
        4, 5: begin
          r.kind = KIND_DEL_AT;
          if ($urandom_range(0, 5) != 0) r.position = 4'($urandom_range(0, last_idx));
        end
        9: r.kind = ($urandom_range(0, 3) == 0) ? KIND_CLEAR : KIND_READ;
        default: begin
          if ($urandom_range(0, 5) != 0) r.position = 4'($urandom_range(0, last_idx));
        end
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch, got %h expected %h", $time, field, got, want);
    mismatch_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance with
  // in_valid still high, so a back-to-back request keeps it up.
  task automatic send_request(req_t r, bit typed, rsp_t want);
    int   gap;
    rsp_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    predicted = apply_list_op(r);
    expected_rsps.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_capacity(logic [4:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we          <= 1'b0;
    shadow_capacity = value;
  endtask

  // result side stall pattern
  always @(negedge clk) begin
    if (no_idle) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall_left = pick_gap();
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected result", out_rsp.first_value, '0);
      end else begin
        oldest_rsp = expected_rsps.pop_front();
        if (out_rsp.succeeded !== oldest_rsp.succeeded)
          report_mismatch("succeeded", 32'(out_rsp.succeeded), 32'(oldest_rsp.succeeded));
        if (out_rsp.entry_count !== oldest_rsp.entry_count)
          report_mismatch("entry_count", 32'(out_rsp.entry_count),
                          32'(oldest_rsp.entry_count));
        if (out_rsp.is_empty !== oldest_rsp.is_empty)
          report_mismatch("is_empty", 32'(out_rsp.is_empty), 32'(oldest_rsp.is_empty));
        if (out_rsp.first_value !== oldest_rsp.first_value)
          report_mismatch("first_value", out_rsp.first_value, oldest_rsp.first_value);
        if (out_rsp.last_value !== oldest_rsp.last_value)
          report_mismatch("last_value", out_rsp.last_value, oldest_rsp.last_value);
        if (out_rsp.read_value !== oldest_rsp.read_value)
          report_mismatch("read_value", out_rsp.read_value, oldest_rsp.read_value);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [4:0]  phase_capacity [PHASES] = '{5'd16, 5'd4, 5'd0, 5'd31, 5'd1,
                                             5'd17, 5'd2, 5'd9, 5'd16, 5'd3};
    int unsigned phase_grow [PHASES] = '{75, 30, 60, 70, 50, 80, 40, 65, 35, 55};
    rsp_t        none_rsp;

    foreach (shadow_list[i]) shadow_list[i] = '0;
    shadow_count    = 0;
    shadow_capacity = 5'd16;
    none_rsp        = mk_rsp(1'b0, 5'd0, '0, '0);

    // refusals on an empty list, then a small list walked through every operation
    add_row(KIND_READ, 4'd0, 32'h0, 1'b1, none_rsp);
    add_row(KIND_DEL_LAST, 4'd0, 32'h0, 1'b1, none_rsp);
    add_row(KIND_DEL_FIRST, 4'd0, 32'h0, 1'b1, none_rsp);
    add_row(KIND_DEL_AT, 4'd0, 32'h0, 1'b1, none_rsp);
    add_row(KIND_DEL_VALUE, 4'd0, 32'h5, 1'b1, none_rsp);
    add_row(KIND_INSERT_AT, 4'd1, 32'h7, 1'b1, none_rsp);
    add_row(KIND_FIRST_UNUSED, 4'd0, 32'h1, 1'b1, none_rsp);
    add_row(KIND_LAST_UNUSED, 4'hF, 32'hFFFF_FFFF, 1'b1, none_rsp);
    add_row(KIND_APPEND, 4'hF, 32'hFFFF_FFFF, 1'b1,
            mk_rsp(1'b1, 5'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    add_row(KIND_PREPEND, 4'd0, 32'h0, 1'b1, mk_rsp(1'b1, 5'd2, 32'h0, 32'hFFFF_FFFF));
    add_row(KIND_INSERT_AT, 4'd1, 32'hA5A5_A5A5);
    add_row(KIND_INSERT_AT, 4'd3, 32'h5A5A_5A5A);
    add_row(KIND_INSERT_AT, 4'd5, 32'h1111_1111);
    add_row(KIND_READ, 4'hF, 32'h0);
    add_row(KIND_READ, 4'd2, 32'h0);
    add_row(KIND_DEL_VALUE, 4'd0, 32'h1234_5678);
    add_row(KIND_DEL_VALUE, 4'd0, 32'hA5A5_A5A5);
    add_row(KIND_DEL_AT, 4'd1, 32'h0);
    add_row(KIND_DEL_AT, 4'd9, 32'h0);
    add_row(KIND_DEL_FIRST, 4'd0, 32'h0);
    add_row(KIND_DEL_LAST, 4'd0, 32'h0);
    add_row(KIND_APPEND, 4'd0, 32'h8000_0001);
    add_row(KIND_CLEAR, 4'd0, 32'h0, 1'b1, mk_rsp(1'b1, 5'd0, '0, '0));
    add_row(KIND_CLEAR, 4'd0, 32'h0, 1'b1, mk_rsp(1'b1, 5'd0, '0, '0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stimulus_table[i])
      send_request(stimulus_table[i].req, stimulus_table[i].typed, stimulus_table[i].want);

    // the list carries over between phases, so lower capacities land below the count
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_capacity[p]);
      no_idle = (p == 3 || p == 7);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if (p == 5 && n == PHASE_REQUESTS / 2) drain_results();
        send_request(random_request(phase_grow[p]), 1'b0, none_rsp);
      end
    end
    no_idle = 1'b0;

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_rsps.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/bol_pkg.sv
rtl/bounded_ordered_list.sv
tb/tb_bounded_ordered_list.sv
